FILE: rtl/fhm_pkg.sv
// ---------------------------------------------------------------------------
// fhm_pkg
// Shared sizes, outcome codes and controller command type for the
// hand-off mutex with a fifo of waiting threads.
// ---------------------------------------------------------------------------
`default_nettype none

package fhm_pkg;

    // sizing
    localparam int WAIT_DEPTH     = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int ID_PORT_BITS   = 8;
    localparam int TID_BITS       = (THREAD_ID_BITS < ID_PORT_BITS) ? THREAD_ID_BITS
                                                                    : ID_PORT_BITS;
    localparam int PTR_BITS       = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_BITS       = $clog2(WAIT_DEPTH + 1);

    // request codes
    localparam logic FUNC_LOCK   = 1'b0;
    localparam logic FUNC_UNLOCK = 1'b1;

    // outcome codes
    localparam logic [2:0] OUT_GRANTED   = 3'd0;
    localparam logic [2:0] OUT_QUEUED    = 3'd1;
    localparam logic [2:0] OUT_DEADLOCK  = 3'd2;
    localparam logic [2:0] OUT_FREED     = 3'd3;
    localparam logic [2:0] OUT_HANDOFF   = 3'd4;
    localparam logic [2:0] OUT_NOT_OWNER = 3'd5;
    localparam logic [2:0] OUT_FULL      = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // resolve the captured request and commit state
    } fhm_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/fhm_ram.sv
// ---------------------------------------------------------------------------
// fhm_ram
// Generic single write port, single read port ram with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module fhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/fhm_ctrl.sv
// ---------------------------------------------------------------------------
// fhm_ctrl
// Request sequencer: takes one item, lets the datapath resolve it, then
// holds the result until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module fhm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fhm_pkg::fhm_cmd_t      cmd
);
    import fhm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // handshake and datapath commands
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign cmd.load  = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec  = (state_reg == S_EXEC);

endmodule

`default_nettype wire

FILE: rtl/fhm_dp.sv
// ---------------------------------------------------------------------------
// fhm_dp
// Mutex datapath: owner and lock flag, wait fifo pointers and storage,
// and the result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module fhm_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fhm_pkg::fhm_cmd_t              cmd,
    input  wire logic                           func,
    input  wire logic [fhm_pkg::ID_PORT_BITS-1:0] thread_id,
    input  wire logic                           others_runnable,
    output logic      [2:0]                     outcome,
    output logic      [fhm_pkg::ID_PORT_BITS-1:0] woken_thread,
    output logic                                is_locked
);
    import fhm_pkg::*;

    // captured request
    logic                func_reg;
    logic                func_next;
    logic [TID_BITS-1:0] tid_reg;
    logic [TID_BITS-1:0] tid_next;
    logic                run_reg;
    logic                run_next;

    // mutex state
    logic                locked_reg;
    logic                locked_next;
    logic [TID_BITS-1:0] owner_reg;
    logic [TID_BITS-1:0] owner_next;
    logic [PTR_BITS-1:0] head_reg;
    logic [PTR_BITS-1:0] head_next;
    logic [PTR_BITS-1:0] tail_reg;
    logic [PTR_BITS-1:0] tail_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    // result
    logic [2:0]              outcome_reg;
    logic [2:0]              outcome_next;
    logic [ID_PORT_BITS-1:0] woken_reg;
    logic [ID_PORT_BITS-1:0] woken_next;
    logic                    is_locked_reg;
    logic                    is_locked_next;

    // wait fifo storage
    logic                we;
    logic [TID_BITS-1:0] head_tid;

    fhm_ram #(
        .WIDTH (TID_BITS),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (we),
        .waddr (tail_reg),
        .wdata (tid_reg),
        .raddr (head_reg),
        .rdata (head_tid)
    );

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(WAIT_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // request resolution
    always_comb
    begin
        func_next      = func_reg;
        tid_next       = tid_reg;
        run_next       = run_reg;
        locked_next    = locked_reg;
        owner_next     = owner_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        outcome_next   = outcome_reg;
        woken_next     = woken_reg;
        is_locked_next = is_locked_reg;
        we             = 1'b0;

        if (cmd.load)
        begin
            func_next = func;
            tid_next  = thread_id[TID_BITS-1:0];
            run_next  = others_runnable;
        end

        if (cmd.exec)
        begin
            woken_next = '0;
            if (func_reg == FUNC_LOCK)
            begin
                if (!locked_reg)
                begin
                    locked_next  = 1'b1;
                    owner_next   = tid_reg;
                    outcome_next = OUT_GRANTED;
                end
                else if (!run_reg)
                begin
                    outcome_next = OUT_DEADLOCK;
                end
                else if (count_reg == CNT_BITS'(WAIT_DEPTH))
                begin
                    outcome_next = OUT_FULL;
                end
                else
                begin
                    we           = 1'b1;
                    tail_next    = next_slot(tail_reg);
                    count_next   = count_reg + 1'b1;
                    outcome_next = OUT_QUEUED;
                end
            end
            else
            begin
                if (!locked_reg || (owner_reg != tid_reg))
                begin
                    outcome_next = OUT_NOT_OWNER;
                end
                else if (count_reg != '0)
                begin
                    // hand ownership to the oldest waiter
                    woken_next   = ID_PORT_BITS'(head_tid);
                    owner_next   = head_tid;
                    head_next    = next_slot(head_reg);
                    count_next   = count_reg - 1'b1;
                    outcome_next = OUT_HANDOFF;
                end
                else
                begin
                    locked_next  = 1'b0;
                    owner_next   = '0;
                    outcome_next = OUT_FREED;
                end
            end
            is_locked_next = locked_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            owner_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        tid_reg       <= tid_next;
        run_reg       <= run_next;
        outcome_reg   <= outcome_next;
        woken_reg     <= woken_next;
        is_locked_reg <= is_locked_next;
    end

    assign outcome      = outcome_reg;
    assign woken_thread = woken_reg;
    assign is_locked    = is_locked_reg;

endmodule

`default_nettype wire

FILE: rtl/fifo_handoff_mutex_core.sv
// ---------------------------------------------------------------------------
// fifo_handoff_mutex_core
// Hardware mutex with a fifo of waiting threads and direct hand off.
//
//   channel  | handshake          | fields
//   ---------+--------------------+-----------------------------------
//   request  | in_valid/in_stall  | func, thread_id, others_runnable
//   result   | out_valid/out_stall| outcome, woken_thread, is_locked
//
// Each item goes through capture, resolve, then present the result.
// The registered read of the wait ram sets the resolve step, and one item
// is in flight at a time. in_stall stays high until the result is taken.
// Reset clears the lock, owner and fifo pointers; fifo storage needs no clear.
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_handoff_mutex_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             func,
    input  wire logic [fhm_pkg::ID_PORT_BITS-1:0] thread_id,
    input  wire logic                             others_runnable,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [2:0]                       outcome,
    output logic      [fhm_pkg::ID_PORT_BITS-1:0] woken_thread,
    output logic                                  is_locked
);
    import fhm_pkg::*;

    fhm_cmd_t cmd;

    // sequencer
    fhm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // mutex datapath
    fhm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .func            (func),
        .thread_id       (thread_id),
        .others_runnable (others_runnable),
        .outcome         (outcome),
        .woken_thread    (woken_thread),
        .is_locked       (is_locked)
    );

endmodule

`default_nettype wire
